[hw/rtl/class_label_inertia_filter_unit_defines.svh]
// Assertion macros used by the inertia filter top level.
`ifndef CLASS_LABEL_INERTIA_FILTER_UNIT_DEFINES_SVH
`define CLASS_LABEL_INERTIA_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CLIF_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CLIF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/clif_pkg.sv]
// Shared types and constants for the class label inertia filter.
`timescale 1ns / 1ps
`default_nettype none

package clif_pkg;

	localparam int LABEL_W    = 4;   // raw label field
	localparam int SHOWN_W    = 3;   // displayed label field
	localparam int HOLD_W     = 16;  // reported hold count
	localparam int THR_W      = 8;   // one switch threshold
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int THR_PER_ROW = CFG_DATA_W / THR_W;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               clear;
	} item_t;

	typedef struct packed {
		logic [SHOWN_W-1:0] shown_label;
		logic [HOLD_W-1:0]  hold_count;
		logic               label_error;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/clif_thr_regs.sv]
// Switch threshold register file with (shown, candidate) lookup.
`timescale 1ns / 1ps
`default_nettype none

module clif_thr_regs #(
	parameter int NUM_LABELS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [clif_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [clif_pkg::CFG_DATA_W-1:0]     wr_data,
	input  wire logic [$clog2(NUM_LABELS)-1:0]       row_sel,
	input  wire logic [$clog2(NUM_LABELS)-1:0]       col_sel,
	output logic      [clif_pkg::THR_W-1:0]          need
);
	import clif_pkg::*;

	localparam int LBL_W = $clog2(NUM_LABELS);

	// only bytes for real labels are kept
	logic [NUM_LABELS-1:0][NUM_LABELS-1:0][THR_W-1:0] thr_q;
	logic                                             row_hit;

	assign row_hit = wr_en && (wr_index < CFG_IDX_W'(NUM_LABELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (row_hit) begin
			for (int j = 0; j < NUM_LABELS; j++) begin
				thr_q[wr_index[LBL_W-1:0]][j] <= wr_data[j*THR_W +: THR_W];
			end
		end
	end

	assign need = thr_q[row_sel][col_sel];

endmodule

`default_nettype wire

[hw/rtl/clif_filter.sv]
// Inertia state registers and their per-word update logic.
`timescale 1ns / 1ps
`default_nettype none

module clif_filter #(
	parameter int NUM_LABELS  = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire clif_pkg::item_t                item,
	input  wire logic [clif_pkg::THR_W-1:0]     need,
	output logic      [$clog2(NUM_LABELS)-1:0]  row_sel,
	output logic      [$clog2(NUM_LABELS)-1:0]  col_sel,
	output clif_pkg::result_t                   result
);
	import clif_pkg::*;

	localparam int LBL_W = $clog2(NUM_LABELS);
	localparam int CW    = COUNT_WIDTH;

	logic [LBL_W-1:0] shown_q, shown_b, shown_n;
	logic             shown_vld_q, shown_vld_b, shown_vld_n;
	logic [CW-1:0]    hold_q, hold_b, hold_n;
	logic [LBL_W-1:0] pend_q, pend_b, pend_n;
	logic             pend_vld_q, pend_vld_b, pend_vld_n;
	logic [CW-1:0]    pend_cnt_q, pend_cnt_b, pend_cnt_n;
	logic             bad_label;
	logic [LBL_W-1:0] lab;
	logic [HOLD_W-1:0] hold_rep;

	assign bad_label = item.label >= LABEL_W'(NUM_LABELS);
	assign lab       = item.label[LBL_W-1:0];
	// with clear set the switch branch is never taken, so the live row is fine
	assign row_sel   = shown_q;
	assign col_sel   = lab;

	always_comb begin
		// clear takes effect before the label is looked at
		if (item.clear) begin
			shown_b     = '0;
			shown_vld_b = 1'b0;
			hold_b      = '0;
			pend_b      = '0;
			pend_vld_b  = 1'b0;
			pend_cnt_b  = '0;
		end else begin
			shown_b     = shown_q;
			shown_vld_b = shown_vld_q;
			hold_b      = hold_q;
			pend_b      = pend_q;
			pend_vld_b  = pend_vld_q;
			pend_cnt_b  = pend_cnt_q;
		end

		shown_n     = shown_b;
		shown_vld_n = shown_vld_b;
		hold_n      = hold_b;
		pend_n      = pend_b;
		pend_vld_n  = pend_vld_b;
		pend_cnt_n  = pend_cnt_b;

		if (bad_label) begin
			// state left alone
		end else if (!shown_vld_b) begin
			shown_n     = lab;
			shown_vld_n = 1'b1;
			hold_n      = CW'(1);
			pend_n      = '0;
			pend_vld_n  = 1'b0;
			pend_cnt_n  = '0;
		end else if (lab == shown_b) begin
			hold_n     = (hold_b == '1) ? hold_b : hold_b + CW'(1);
			pend_n     = '0;
			pend_vld_n = 1'b0;
			pend_cnt_n = '0;
		end else begin
			if (pend_vld_b && (pend_b == lab)) begin
				pend_cnt_n = (pend_cnt_b == '1) ? pend_cnt_b : pend_cnt_b + CW'(1);
			end else begin
				pend_n     = lab;
				pend_vld_n = 1'b1;
				pend_cnt_n = CW'(1);
			end
			if (pend_cnt_n >= CW'(need)) begin
				shown_n    = lab;
				hold_n     = pend_cnt_n;
				pend_n     = '0;
				pend_vld_n = 1'b0;
				pend_cnt_n = '0;
			end
		end
	end

	generate
		if (CW > HOLD_W) begin : g_hold_sat
			assign hold_rep = (hold_n > CW'({HOLD_W{1'b1}})) ? '1 : hold_n[HOLD_W-1:0];
		end else begin : g_hold_ext
			assign hold_rep = HOLD_W'(hold_n);
		end
	endgenerate

	always_comb begin
		result.label_error = bad_label;
		if (shown_vld_n) begin
			result.shown_label = SHOWN_W'(shown_n);
			result.hold_count  = hold_rep;
		end else begin
			result.shown_label = '0;
			result.hold_count  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q     <= '0;
			shown_vld_q <= 1'b0;
			hold_q      <= '0;
			pend_q      <= '0;
			pend_vld_q  <= 1'b0;
			pend_cnt_q  <= '0;
		end else if (step) begin
			shown_q     <= shown_n;
			shown_vld_q <= shown_vld_n;
			hold_q      <= hold_n;
			pend_q      <= pend_n;
			pend_vld_q  <= pend_vld_n;
			pend_cnt_q  <= pend_cnt_n;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/class_label_inertia_filter_unit.sv]
// Top level of the class label inertia filter: input stage, filter, result register.
//
// Debounces a stream of classifier labels: each input word (label, clear) yields exactly one
// output word (shown_label, hold_count, label_error). The first in-range label after reset or
// clear is shown at once; a different label must repeat for the number of consecutive words
// given by the threshold byte for (shown, new) before it takes over, and a word matching the
// shown label drops any candidate. Counters saturate; an out-of-range label only raises
// label_error (after honoring clear). The block takes one word per clock unless output stalls:
// the word is captured in an input register, then the filter state is updated and the result
// captured in the output register. One word per clock is set by the state update loop,
// which reads and writes the filter state in the same cycle.
// Output back-pressure stalls both stages; in_ready drops only when both registers hold words
// and out_ready is low. Thresholds are written through the cfg port (index i = row for shown
// label i, byte j = threshold toward label j); cfg_ready is always high, indexes past the last
// label are dropped, and rows must only be written while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "class_label_inertia_filter_unit_defines.svh"

module class_label_inertia_filter_unit #(
	parameter int NUM_LABELS  = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input words
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [clif_pkg::LABEL_W-1:0]        label,
	input  wire logic                                clear,
	// result words
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [clif_pkg::SHOWN_W-1:0]        shown_label,
	output logic      [clif_pkg::HOLD_W-1:0]         hold_count,
	output logic                                     label_error,
	// threshold writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [clif_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [clif_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import clif_pkg::*;

	localparam int LBL_W = $clog2(NUM_LABELS);

	item_t            item_s1;
	logic             valid_s1;
	result_t          res_s2;
	logic             valid_s2;
	logic             adv_s1;
	logic             in_fire;
	result_t          res_next;
	logic [LBL_W-1:0] row_sel;
	logic [LBL_W-1:0] col_sel;
	logic [THR_W-1:0] need;

	assign cfg_ready = 1'b1;

	// stage 1 moves into the result register when that one is empty or draining
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.label <= label;
			item_s1.clear <= clear;
		end
	end

	clif_thr_regs #(
		.NUM_LABELS(NUM_LABELS)
	) u_thr (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.row_sel (row_sel),
		.col_sel (col_sel),
		.need    (need)
	);

	clif_filter #(
		.NUM_LABELS (NUM_LABELS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.need   (need),
		.row_sel(row_sel),
		.col_sel(col_sel),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid   = valid_s2;
	assign shown_label = res_s2.shown_label;
	assign hold_count  = res_s2.hold_count;
	assign label_error = res_s2.label_error;

	`CLIF_ASSERT_NEXT(a_adv_loads_s2, adv_s1, valid_s2, "result register not loaded")
	`CLIF_ASSERT_NOW(a_no_overrun, valid_s1 && valid_s2 && !out_ready, !in_ready,
		"input accepted while both stages are stalled")
	`CLIF_ASSERT_NOW(a_shown_range, valid_s2, shown_label <= SHOWN_W'(NUM_LABELS - 1),
		"shown label beyond label count")
	`CLIF_ASSERT_NOW(a_empty_zero, valid_s2 && (hold_count == '0), shown_label == '0,
		"zero hold count with nonzero label")

endmodule

`default_nettype wire
